/* rtl/core/keyed_permutation_builder_defines.svh */
// ----------------------------------------------------------------------------
// Keyed permutation builder assertion macros
// Shared assertion forms for the permutation builder RTL.
// ----------------------------------------------------------------------------
`ifndef KEYED_PERMUTATION_BUILDER_DEFINES_SVH
`define KEYED_PERMUTATION_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define KPB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/kpb_pkg.sv */
// ----------------------------------------------------------------------------
// kpb_pkg
// Word types, sizes and the primitive root table of the permutation builder.
// ----------------------------------------------------------------------------
`default_nettype none

package kpb_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int PRIME_MOD  = 257;

    // Input word: operation select and key character
    typedef struct packed {
        logic       operation;
        logic [7:0] key_char;
    } t_in_word;

    // Output word: slot written, byte stored, completion and reject flags
    typedef struct packed {
        logic [7:0] position;
        logic [7:0] code;
        logic       done_res;
        logic       rejected;
    } t_out_word;

    localparam logic OP_KEY_CHAR = 1'b0;
    localparam logic OP_FILL     = 1'b1;

    typedef logic [7:0] t_root_tbl [TABLE_SIZE];

    // Largest primitive root of 257 not above c+1, floored at 3.
    // A value g is a primitive root when g^128 == -1 mod 257.
    function automatic t_root_tbl f_build_root_tbl();
        t_root_tbl tbl;
        int        best;
        int        x;
        best = 3;
        for (int c = 0; c < TABLE_SIZE; c++) begin
            if (c + 1 > 3) begin
                x = (c + 1) % PRIME_MOD;
                for (int i = 0; i < 7; i++) begin
                    x = (x * x) % PRIME_MOD;
                end
                if (x == PRIME_MOD - 1) begin
                    best = c + 1;
                end
            end
            tbl[c] = 8'(best);
        end
        return tbl;
    endfunction

    localparam t_root_tbl ROOT_TBL = f_build_root_tbl();

endpackage

`default_nettype wire

/* rtl/core/kpb_ram.sv */
// ----------------------------------------------------------------------------
// kpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/keyed_permutation_builder.sv */
// Flow: a rejected word returns in the cycle after acceptance; a placed word takes
//   a multiply, reduce and test step per taken-map probe, after a code-table read for a fill.
// Words are taken one at a time; a placed word blocks input until its probe walk
//   (up to 256 probes) through the shared 9x8 multiplier finds a free slot.
// Reset: synchronous active low; clears counters and flags, then clears every slot
//   of the taken map before the first word is accepted.
// ----------------------------------------------------------------------------
// keyed_permutation_builder
// Builds a 256-entry byte permutation from a keyword, one entry per word,
// probing the taken map with a shared multiply and mod-257 reduce unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_permutation_builder_defines.svh"

module keyed_permutation_builder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire kpb_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output kpb_pkg::t_out_word      o_out_word
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_RED,
        S_TEST
    } t_state;

    t_state             r_state, n_state;
    logic [7:0]         r_clr_addr, n_clr_addr;
    logic [8:0]         r_count, n_count;
    logic [7:0]         r_rd_ptr, n_rd_ptr;
    logic               r_key_ended, n_key_ended;
    logic [8:0]         r_s1, n_s1;
    logic [7:0]         r_m, n_m;
    logic [15:0]        r_prod, n_prod;
    logic               r_out_valid, n_out_valid;
    kpb_pkg::t_out_word r_out_word, n_out_word;

    logic               w_accept;
    logic               w_out_free;
    logic               w_reject;
    logic [8:0]         w_diff;
    logic [8:0]         w_mod;
    logic [8:0]         w_slot9;
    logic [7:0]         w_slot;
    logic               w_ram_wr_en;
    logic [7:0]         w_ram_rd_data;
    logic               w_taken_wr_en;
    logic [7:0]         w_taken_wr_addr;
    logic               w_taken_wr_data;
    logic               w_taken_rd_data;

    // Code table: written in position order, read back for later fill steps
    kpb_ram #(
        .WIDTH (8),
        .DEPTH (kpb_pkg::TABLE_SIZE)
    ) u_code_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (r_count[7:0]),
        .i_wr_data (w_slot),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_ram_rd_data)
    );

    // Taken map: one flag per slot, read at the current probe slot
    kpb_ram #(
        .WIDTH (1),
        .DEPTH (kpb_pkg::TABLE_SIZE)
    ) u_taken_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_taken_wr_en),
        .i_wr_addr (w_taken_wr_addr),
        .i_wr_data (w_taken_wr_data),
        .i_rd_addr (w_slot),
        .o_rd_data (w_taken_rd_data)
    );

    // Reduce product mod 257 using 256 == -1, then step down by one
    always_comb begin
        w_diff  = {1'b0, r_prod[7:0]} - {1'b0, r_prod[15:8]};
        w_mod   = w_diff[8] ? (w_diff + 9'd257) : w_diff;
        w_slot9 = w_mod - 9'd1;
        w_slot  = w_slot9[7:0];
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_reject   = r_count[8] ||
                        ((i_in_word.operation == kpb_pkg::OP_KEY_CHAR) && r_key_ended);

    // Sequencer: clear the taken map, reject or take each word and choose its character, then walk the probe chain
    always_comb begin
        n_state         = r_state;
        n_clr_addr      = r_clr_addr;
        n_count         = r_count;
        n_rd_ptr        = r_rd_ptr;
        n_key_ended     = r_key_ended;
        n_s1            = r_s1;
        n_m             = r_m;
        n_prod          = r_prod;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_out_word      = r_out_word;
        w_ram_wr_en     = 1'b0;
        w_taken_wr_en   = 1'b0;
        w_taken_wr_addr = w_slot;
        w_taken_wr_data = 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                w_taken_wr_en   = 1'b1;
                w_taken_wr_addr = r_clr_addr;
                w_taken_wr_data = 1'b0;
                n_clr_addr      = r_clr_addr + 8'd1;
                if (r_clr_addr == 8'd255) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    priority if (w_reject) begin
                        n_out_valid = 1'b1;
                        n_out_word  = '{position: 8'd0, code: 8'd0,
                                        done_res: 1'b0, rejected: 1'b1};
                    end else if (i_in_word.operation == kpb_pkg::OP_KEY_CHAR) begin
                        n_m     = kpb_pkg::ROOT_TBL[i_in_word.key_char];
                        n_s1    = {1'b0, i_in_word.key_char} + 9'd1;
                        n_state = S_MUL;
                    end else if (!r_key_ended) begin
                        n_m         = kpb_pkg::ROOT_TBL[0];
                        n_s1        = 9'd1;
                        n_key_ended = 1'b1;
                        n_state     = S_MUL;
                    end else begin
                        n_rd_ptr = r_rd_ptr + 8'd1;
                        n_state  = S_READ;
                    end
                end
            end
            S_READ: begin
                n_m     = kpb_pkg::ROOT_TBL[w_ram_rd_data];
                n_s1    = {1'b0, w_ram_rd_data} + 9'd1;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = 16'({7'd0, r_s1} * {8'd0, r_m});
                n_state = S_RED;
            end
            S_RED: begin
                // Slot is ready; its taken flag arrives next cycle
                n_state = S_TEST;
            end
            S_TEST: begin
                if (w_taken_rd_data) begin
                    n_s1    = {1'b0, w_slot} + 9'd1;
                    n_state = S_MUL;
                end else if (w_out_free) begin
                    w_taken_wr_en = 1'b1;
                    w_ram_wr_en   = 1'b1;
                    n_count       = r_count + 9'd1;
                    n_out_valid   = 1'b1;
                    n_out_word    = '{position: r_count[7:0], code: w_slot,
                                      done_res: (r_count == 9'd255), rejected: 1'b0};
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, datapath and output word
    always_ff @(posedge i_clk) begin
        r_s1       <= n_s1;
        r_m        <= n_m;
        r_prod     <= n_prod;
        r_out_word <= n_out_word;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_rd_ptr    <= '0;
            r_key_ended <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_rd_ptr    <= n_rd_ptr;
            r_key_ended <= n_key_ended;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `KPB_ASSERT_IMP(a_done_last_slot, o_out_valid && o_out_word.done_res,
        (o_out_word.position == 8'd255) && !o_out_word.rejected, "done flag off the last slot")
    `KPB_ASSERT_IMP(a_count_bounded, r_count[8], r_count[7:0] == 8'd0,
        "write count beyond table size")
    `KPB_ASSERT_IMP(a_reject_clean, o_out_valid && o_out_word.rejected,
        (o_out_word.position == 8'd0) && (o_out_word.code == 8'd0) && !o_out_word.done_res,
        "rejected word carries data")
    `KPB_ASSERT_IMP(a_read_behind_write, 1'b1, {1'b0, r_rd_ptr} <= r_count,
        "read pointer ahead of writes")
    `KPB_ASSERT_NEXT(a_fill_read_step,
        w_accept && !w_reject && (i_in_word.operation == kpb_pkg::OP_FILL) && r_key_ended,
        r_state == S_READ, "fill step skipped table read")

endmodule

`default_nettype wire
